FILE: rtl/chol_pkg.sv
// shared types, constants and index helpers for the cholesky factorizer
package chol_pkg;

  localparam int MaxDim    = 8;
  localparam int FracBits  = 28;
  localparam int Depth     = MaxDim * (MaxDim + 1) / 2;
  localparam int AddrW     = $clog2(Depth);
  localparam int DimW      = $clog2(MaxDim + 1);
  localparam int IdxW      = $clog2(MaxDim);
  localparam int CntW      = $clog2(Depth + 1);
  localparam int SqW       = 64;
  localparam int SqSteps   = SqW / 2;
  localparam int DivSteps  = SqW;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DOT_RD,
    ST_DOT_WAIT,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_DIFF,
    ST_DIAG_RD,
    ST_UNIT,
    ST_UNIT_WAIT,
    ST_WRITE,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT
  } state_t;

  // request and answer between sequencer and the shared root and divide unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] num;
    logic [31:0] den;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } unit_rsp_t;

  // triangle address of row r, column c
  function automatic logic [AddrW-1:0] tri_addr(input logic [IdxW-1:0] r,
                                               input logic [IdxW-1:0] c);
    logic [AddrW+IdxW:0] t;
    t = ((AddrW+IdxW+1)'(r) * ((AddrW+IdxW+1)'(r) + 1'b1)) >> 1;
    return AddrW'(t + (AddrW+IdxW+1)'(c));
  endfunction

endpackage

FILE: rtl/chol_ram.sv
// generic single-port ram with registered read
module chol_ram #(
  parameter int Width = 32,
  parameter int Depth = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/chol_unit.sv
// shared iterative unit: bit-serial square root or restoring divide
module chol_unit
  import chol_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic        mode_sqrt;
  logic [6:0]  step;
  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [31:0] den;
  logic [63:0] num;

  logic [64:0] rem_sh;
  logic [63:0] trial;

  assign rem_sh = {rem, num[63]};
  assign trial  = res + bitv;

  // one root digit or one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy      <= 1'b1;
        mode_sqrt <= req.is_sqrt;
        x         <= req.num;
        num       <= req.num;
        den       <= req.den;
        res       <= '0;
        bitv      <= 64'h4000_0000_0000_0000;
        rem       <= '0;
        quo       <= '0;
        step      <= '0;
      end else if (busy) begin
        step <= step + 7'd1;
        if (mode_sqrt) begin
          if (x >= trial) begin
            x   <= x - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (step == 7'(SqSteps - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          num <= num << 1;
          if (rem_sh >= 65'(den)) begin
            rem <= 64'(rem_sh - 65'(den));
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= 64'(rem_sh);
            quo <= {quo[62:0], 1'b0};
          end
          if (step == 7'(DivSteps - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign rsp = '{done: done, result: (mode_sqrt ? res : quo)};

endmodule

FILE: rtl/cholesky_factorizer_core.sv
// cholesky factorizer top level: load, sequencer, stores and output register
//
//  channel   direction  handshake                   payload
//  entry     in         entry_valid / entry_ready   entry_value
//  factor    out        factor_valid / factor_ready value, row, col, last, status
//  config    in         cfg_we                      cfg_wdata (matrix_size)
//
// Loading takes one word per cycle. The last word starts the factorization:
// each entry of L accumulates its dot-product terms and then passes through
// the shared root and divide unit; afterwards every word of L is emitted.
// No word is accepted while factoring or emitting. Synchronous reset clears the
// sequencer and counters, sets the size register to 2; stores are not cleared.
module cholesky_factorizer_core
  import chol_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        entry_valid,
  output logic        entry_ready,
  input  logic [31:0] entry_value,
  output logic        factor_valid,
  input  logic        factor_ready,
  output logic [31:0] factor_value,
  output logic [2:0]  row_index,
  output logic [2:0]  col_index,
  output logic        last_entry,
  output logic        status
);

  state_t state, state_next;

  logic [3:0]      msize;
  logic [DimW-1:0] dim;
  logic [CntW-1:0] total;
  logic [CntW-1:0] load_count;
  logic            perr;
  logic [IdxW-1:0] ri, ci, kk;
  logic [CntW-1:0] emit_cnt;

  logic             a_we, f_we;
  logic [AddrW-1:0] a_addr, f_addr;
  logic [31:0]      a_rdata, f_rdata, f_wdata;

  logic signed [31:0] fa;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] d;
  logic signed [31:0] val;
  unit_req_t          req;
  unit_rsp_t          rsp;
  logic               neg;

  // effective dimension and triangle size
  always_comb begin
    if (msize == 4'd0) begin
      dim = DimW'(1);
    end else if (msize > 4'(MaxDim)) begin
      dim = DimW'(MaxDim);
    end else begin
      dim = DimW'(msize);
    end
    total = CntW'((32'(dim) * (32'(dim) + 32'd1)) >> 1);
  end

  chol_ram #(.Width(32), .Depth(Depth)) u_mat (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(entry_value), .rdata(a_rdata));
  chol_ram #(.Width(32), .Depth(Depth)) u_fac (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata));
  chol_unit u_unit (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // rounded product of two factor words
  logic signed [63:0] prod_rnd;
  assign prod_rnd = (prod + (64'sd1 <<< (FracBits - 1))) >>> FracBits;

  // full-width difference, saturated when it is registered into d
  logic signed [64:0] diff_w;
  assign diff_w = 65'(signed'(a_rdata)) - 65'(acc);

  // saturate unit result to signed 32
  logic signed [63:0] q_signed;
  always_comb begin
    q_signed = neg ? -signed'(rsp.result) : signed'(rsp.result);
    if (rsp.result > 64'h7fff_ffff && !neg) begin
      val = 32'sh7fff_ffff;
    end else if (rsp.result > 64'h8000_0000 && neg) begin
      val = 32'sh8000_0000;
    end else begin
      val = 32'(q_signed);
    end
  end

  // sequencer next state and ram addressing
  always_comb begin
    state_next  = state;
    entry_ready = (state == ST_LOAD);
    a_we        = 1'b0;
    f_we        = 1'b0;
    a_addr      = tri_addr(ri, ci);
    f_addr      = tri_addr(ri, kk);
    f_wdata     = val;
    req.start   = 1'b0;
    req.is_sqrt = (ri == ci);
    req.num     = 64'(d < 0 ? -d : d) << FracBits;
    req.den     = f_rdata;
    case (state)
      ST_LOAD: begin
        a_addr = AddrW'(load_count);
        if (entry_valid) begin
          a_we = 1'b1;
          if (load_count + 1'b1 >= total) begin
            state_next = ST_DOT_RD;
          end
        end
      end
      ST_DOT_RD: begin
        f_addr = tri_addr(ri, kk);
        state_next = (kk == ci) ? ST_DIFF : ST_DOT_WAIT;
      end
      ST_DOT_WAIT: begin
        f_addr = tri_addr(ci, kk);
        state_next = ST_DOT_MUL;
      end
      ST_DOT_MUL: state_next = ST_DOT_ACC;
      ST_DOT_ACC: state_next = ST_DOT_RD;
      ST_DIFF: begin
        state_next = ST_DIAG_RD;
      end
      ST_DIAG_RD: begin
        f_addr = tri_addr(ci, ci);
        state_next = ST_UNIT;
      end
      ST_UNIT: begin
        if (ri == ci ? d < 0 : signed'(f_rdata) <= 0) begin
          // failed pivot stores zero
          f_addr     = tri_addr(ri, ci);
          f_wdata    = '0;
          f_we       = 1'b1;
          state_next = ST_WRITE;
        end else begin
          req.start  = 1'b1;
          state_next = ST_UNIT_WAIT;
        end
      end
      ST_UNIT_WAIT: begin
        f_addr = tri_addr(ri, ci);
        if (rsp.done) begin
          f_we = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        f_addr = tri_addr(ri, ci);
        state_next = (ri == IdxW'(dim - 1'b1) && ci == ri) ? ST_EMIT_RD : ST_DOT_RD;
      end
      ST_EMIT_RD: begin
        f_addr = tri_addr(ri, ci);
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (factor_ready) begin
          state_next = (emit_cnt + 1'b1 == total) ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else if (cfg_we) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      msize      <= 4'd2;
      load_count <= '0;
      perr       <= 1'b0;
      ri <= '0; ci <= '0; kk <= '0; emit_cnt <= '0;
    end else if (cfg_we) begin
      msize      <= cfg_wdata;
      load_count <= '0;
      perr       <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (entry_valid) begin
            load_count <= load_count + 1'b1;
            ri <= '0; ci <= '0; kk <= '0; acc <= '0;
          end
        end
        ST_DOT_RD: ;
        ST_DOT_WAIT: fa <= f_rdata;
        ST_DOT_MUL: prod <= 64'(fa) * 64'(signed'(f_rdata));
        ST_DOT_ACC: begin
          acc <= acc + prod_rnd;
          kk  <= kk + 1'b1;
        end
        ST_DIFF: begin
          if (diff_w > 65'sh7fff_ffff) begin
            d <= 64'sh7fff_ffff;
          end else if (diff_w < -65'sh8000_0000) begin
            d <= -64'sh8000_0000;
          end else begin
            d <= 64'(diff_w);
          end
          neg <= (ri != ci) && (diff_w < 0);
        end
        ST_UNIT: begin
          if (state_next == ST_WRITE) begin
            perr <= 1'b1;
          end
        end
        ST_WRITE: begin
          acc <= '0;
          kk  <= '0;
          if (ri == IdxW'(dim - 1'b1) && ci == ri) begin
            ri <= '0; ci <= '0; emit_cnt <= '0;
          end else if (ci == ri) begin
            ri <= ri + 1'b1;
            ci <= '0;
          end else begin
            ci <= ci + 1'b1;
          end
        end
        ST_EMIT_WAIT: begin
          factor_value <= f_rdata;
          row_index    <= 3'(ri);
          col_index    <= 3'(ci);
          last_entry   <= (emit_cnt + 1'b1 == total);
          status       <= perr;
        end
        ST_EMIT: begin
          if (factor_ready) begin
            emit_cnt <= emit_cnt + 1'b1;
            if (ci == ri) begin
              ri <= ri + 1'b1;
              ci <= '0;
            end else begin
              ci <= ci + 1'b1;
            end
            if (emit_cnt + 1'b1 == total) begin
              load_count <= '0;
              perr       <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign factor_valid = (state == ST_EMIT);

endmodule
